/* rtl/core/ftp_reply_parser_macros.svh */
// Assertion macros shared by the FTP reply parser RTL.
`ifndef FTP_REPLY_PARSER_MACROS_SVH
`define FTP_REPLY_PARSER_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define FRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define FRP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/ftp_rp_pkg.sv */
// Shared constants and result type of the FTP reply parser.
package ftp_rp_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [9:0] PASSIVE_CODE_RESET = 10'd227;

  localparam logic [2:0] FIELD_COUNT = 3'd6;
  localparam logic [2:0] LAST_FIELD  = 3'd5;
  localparam logic [2:0] ADDR_FIELDS = 3'd4;
  localparam logic [8:0] FIELD_SAT   = 9'd256;
  localparam logic [8:0] FIELD_MAX   = 9'd255;
  localparam logic [1:0] CODE_DIGITS = 2'd3;

  typedef struct packed {
    logic        code_valid;
    logic [9:0]  reply_code;
    logic        passive_ok;
    logic [7:0]  addr_byte_0;
    logic [7:0]  addr_byte_1;
    logic [7:0]  addr_byte_2;
    logic [7:0]  addr_byte_3;
    logic [15:0] port_number;
  } ftp_rp_result_t;

endpackage

/* rtl/core/ftp_rp_parse.sv */
// Line state machine, reply code and passive address parser.
module ftp_rp_parse
  import ftp_rp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [7:0]     rx_byte,
  input  logic [9:0]     passive_code,
  output logic           emit,
  output ftp_rp_result_t result
);

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_SINGLE = 2'd1;
  localparam logic [1:0] PH_MULTI  = 2'd2;

  logic [1:0] line_phase, line_phase_next;
  logic [1:0] char_count, char_count_next;
  logic [9:0] code_accum, code_accum_next;
  logic       code_digits_ok, code_digits_ok_next;
  logic       paren_seen, paren_seen_next;
  logic [2:0] field_index, field_index_next;
  logic [8:0] field_accum, field_accum_next;
  logic       field_stopped, field_stopped_next;
  logic       field_started, field_started_next;
  logic       field_past_lead, field_past_lead_next;
  logic       field_negative, field_negative_next;
  logic       line_cut, line_cut_next;
  logic [7:0] addr_fields [4];
  logic [7:0] addr_fields_next [4];
  logic [7:0] port_parts [2];
  logic [7:0] port_parts_next [2];
  logic       pasv_error, pasv_error_next;

  logic        is_digit;
  logic [3:0]  digit;
  logic [13:0] code_step;
  logic [11:0] field_step;
  logic [8:0]  field_sat;
  logic        fin_err;
  logic [7:0]  fin_val;
  logic [7:0]  delim;
  logic        clear_all;
  logic        end_rep;
  logic        pend;
  logic [2:0]  idx_final;
  logic        err_final;
  logic [7:0]  port_low;
  logic        code_ok;
  logic        pasv_ok;

  always_comb begin
    is_digit   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    digit      = rx_byte[3:0];
    code_step  = ({4'd0, code_accum} << 3) + ({4'd0, code_accum} << 1) + {10'd0, digit};
    field_step = ({3'd0, field_accum} << 3) + ({3'd0, field_accum} << 1) + {8'd0, digit};
    field_sat  = (field_step > {3'd0, FIELD_SAT}) ? FIELD_SAT : field_step[8:0];
    fin_err    = (field_accum > FIELD_MAX) || (field_negative && (field_accum != 9'd0));
    fin_val    = field_negative ? 8'd0 : field_accum[7:0];
    delim      = (field_index == LAST_FIELD) ? CH_RPAREN : CH_COMMA;
    end_rep    = (rx_byte == CH_LF) && (line_phase != PH_MULTI);

    pend      = (field_index == LAST_FIELD) && field_started;
    idx_final = pend ? FIELD_COUNT : field_index;
    err_final = pasv_error || (pend && fin_err);
    port_low  = pend ? fin_val : port_parts[1];
    code_ok   = (char_count == CODE_DIGITS) && code_digits_ok;
    pasv_ok   = code_ok && (code_accum == passive_code) && paren_seen &&
                (idx_final == FIELD_COUNT) && !err_final;

    result.code_valid  = code_ok;
    result.reply_code  = code_ok ? code_accum : 10'd0;
    result.passive_ok  = pasv_ok;
    result.addr_byte_0 = pasv_ok ? addr_fields[0] : 8'd0;
    result.addr_byte_1 = pasv_ok ? addr_fields[1] : 8'd0;
    result.addr_byte_2 = pasv_ok ? addr_fields[2] : 8'd0;
    result.addr_byte_3 = pasv_ok ? addr_fields[3] : 8'd0;
    result.port_number = pasv_ok ? {port_parts[0], port_low} : 16'd0;

    emit = step && end_rep;

    line_phase_next      = line_phase;
    char_count_next      = char_count;
    code_accum_next      = code_accum;
    code_digits_ok_next  = code_digits_ok;
    paren_seen_next      = paren_seen;
    field_index_next     = field_index;
    field_accum_next     = field_accum;
    field_stopped_next   = field_stopped;
    field_started_next   = field_started;
    field_past_lead_next = field_past_lead;
    field_negative_next  = field_negative;
    line_cut_next        = line_cut;
    addr_fields_next     = addr_fields;
    port_parts_next      = port_parts;
    pasv_error_next      = pasv_error;
    clear_all            = 1'b0;

    if (step) begin
      if (rx_byte == CH_LF) begin
        clear_all       = 1'b1;
        line_phase_next = PH_START;
      end else if ((line_phase == PH_START) && (rx_byte == CH_SP)) begin
        line_phase_next = PH_SINGLE;
      end else if ((line_phase == PH_START) && (rx_byte == CH_MINUS)) begin
        line_phase_next = PH_MULTI;
      end else begin
        if (char_count != CODE_DIGITS) begin
          if (is_digit) begin
            code_accum_next = code_step[9:0];
          end else begin
            code_digits_ok_next = 1'b0;
          end
          char_count_next = char_count + 2'd1;
        end
        if (!line_cut) begin
          if (rx_byte == CH_NUL) begin
            line_cut_next = 1'b1;
          end else if (!paren_seen) begin
            paren_seen_next = (rx_byte == CH_LPAREN);
          end else if (field_index < FIELD_COUNT) begin
            if (rx_byte == delim) begin
              if (field_started) begin
                pasv_error_next = pasv_error || fin_err;
                if (field_index < ADDR_FIELDS) begin
                  addr_fields_next[field_index[1:0]] = fin_val;
                end else begin
                  port_parts_next[field_index[0]] = fin_val;
                end
                field_index_next     = field_index + 3'd1;
                field_accum_next     = 9'd0;
                field_stopped_next   = 1'b0;
                field_started_next   = 1'b0;
                field_past_lead_next = 1'b0;
                field_negative_next  = 1'b0;
              end
            end else begin
              field_started_next = 1'b1;
              if (!field_stopped) begin
                if (is_digit) begin
                  field_accum_next     = field_sat;
                  field_past_lead_next = 1'b1;
                end else if (!field_past_lead && (rx_byte inside {CH_SP, [CH_TAB:CH_CR]})) begin
                  field_stopped_next = 1'b0;
                end else if (!field_past_lead && (rx_byte == CH_PLUS)) begin
                  field_past_lead_next = 1'b1;
                end else if (!field_past_lead && (rx_byte == CH_MINUS)) begin
                  field_past_lead_next = 1'b1;
                  field_negative_next  = 1'b1;
                end else begin
                  field_stopped_next = 1'b1;
                end
              end
            end
          end
        end
      end
    end

    if (clear_all) begin
      char_count_next      = 2'd0;
      code_accum_next      = 10'd0;
      code_digits_ok_next  = 1'b1;
      paren_seen_next      = 1'b0;
      field_index_next     = 3'd0;
      field_accum_next     = 9'd0;
      field_stopped_next   = 1'b0;
      field_started_next   = 1'b0;
      field_past_lead_next = 1'b0;
      field_negative_next  = 1'b0;
      line_cut_next        = 1'b0;
      addr_fields_next     = '{default: 8'd0};
      port_parts_next      = '{default: 8'd0};
      pasv_error_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_phase      <= PH_START;
      char_count      <= 2'd0;
      code_accum      <= 10'd0;
      code_digits_ok  <= 1'b1;
      paren_seen      <= 1'b0;
      field_index     <= 3'd0;
      field_accum     <= 9'd0;
      field_stopped   <= 1'b0;
      field_started   <= 1'b0;
      field_past_lead <= 1'b0;
      field_negative  <= 1'b0;
      line_cut        <= 1'b0;
      addr_fields     <= '{default: 8'd0};
      port_parts      <= '{default: 8'd0};
      pasv_error      <= 1'b0;
    end else begin
      line_phase      <= line_phase_next;
      char_count      <= char_count_next;
      code_accum      <= code_accum_next;
      code_digits_ok  <= code_digits_ok_next;
      paren_seen      <= paren_seen_next;
      field_index     <= field_index_next;
      field_accum     <= field_accum_next;
      field_stopped   <= field_stopped_next;
      field_started   <= field_started_next;
      field_past_lead <= field_past_lead_next;
      field_negative  <= field_negative_next;
      line_cut        <= line_cut_next;
      addr_fields     <= addr_fields_next;
      port_parts      <= port_parts_next;
      pasv_error      <= pasv_error_next;
    end
  end

endmodule

/* rtl/core/ftp_rp_out.sv */
// Output register that holds one result beat until it is taken.
module ftp_rp_out
  import ftp_rp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  ftp_rp_result_t res_in,
  input  logic           out_ready,
  output logic           out_valid,
  output logic           free,
  output ftp_rp_result_t res_out
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

/* rtl/core/ftp_reply_parser.sv */
// Top level of the FTP reply parser: input register, parser and result register.
//
//   channel  direction  handshake             data
//   cfg      in         cfg_valid/cfg_ready   passive_reply_code
//   in       in         in_valid/in_ready     rx_byte
//   out      out        out_valid/out_ready   code_valid .. port_number
//
// One byte is accepted per cycle unless the result register stalls the input.
// A result is registered when the parser steps on the byte that ends a reply.
// Reset is synchronous and clears all line state and restores code 227.
// A full, untaken result register holds the byte in the input register,
// which then drops in_ready; bytes that end no reply still wait their turn.
`include "ftp_reply_parser_macros.svh"

module ftp_reply_parser
  import ftp_rp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  passive_reply_code,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        code_valid,
  output logic [9:0]  reply_code,
  output logic        passive_ok,
  output logic [7:0]  addr_byte_0,
  output logic [7:0]  addr_byte_1,
  output logic [7:0]  addr_byte_2,
  output logic [7:0]  addr_byte_3,
  output logic [15:0] port_number
);

  logic [9:0]     passive_code;
  logic           in_q_valid;
  logic [7:0]     in_q_byte;
  logic           out_free;
  logic           step;
  logic           emit;
  ftp_rp_result_t parse_res;
  ftp_rp_result_t out_res;

  assign cfg_ready = 1'b1;
  assign step      = in_q_valid && out_free;
  assign in_ready  = !in_q_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      passive_code <= PASSIVE_CODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      passive_code <= passive_reply_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_byte <= rx_byte;
    end
  end

  ftp_rp_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .rx_byte      (in_q_byte),
    .passive_code (passive_code),
    .emit         (emit),
    .result       (parse_res)
  );

  ftp_rp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .res_in    (parse_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (out_free),
    .res_out   (out_res)
  );

  assign code_valid  = out_res.code_valid;
  assign reply_code  = out_res.reply_code;
  assign passive_ok  = out_res.passive_ok;
  assign addr_byte_0 = out_res.addr_byte_0;
  assign addr_byte_1 = out_res.addr_byte_1;
  assign addr_byte_2 = out_res.addr_byte_2;
  assign addr_byte_3 = out_res.addr_byte_3;
  assign port_number = out_res.port_number;

  `FRP_ASSERT_IMP(a_pasv_needs_code, out_valid && passive_ok, code_valid && (reply_code == passive_code), "passive result without a matching code")
  `FRP_ASSERT_IMP(a_code_zero, out_valid && !code_valid, reply_code == 10'd0, "invalid code is not zero")
  `FRP_ASSERT_IMP(a_pasv_zero, out_valid && !passive_ok, (port_number == 16'd0) && (addr_byte_0 == 8'd0) && (addr_byte_3 == 8'd0), "address fields set without a passive result")
  `FRP_ASSERT(a_no_lost_byte, !in_ready |-> (in_q_valid && out_valid && !out_ready), "input stalled without a full result register")

endmodule
